// ===== src/ctr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctr_pkg
// Shared types and constants for the chunked telemetry receiver.
// ----------------------------------------------------------------------------
package ctr_pkg;

    // Byte and store banking
    localparam int BYTE_W    = 8;
    localparam int NUM_BANKS = 8;
    localparam int BANK_W    = 3;

    // Item fields
    localparam int CMD_W     = 2;
    localparam int INDEX_W   = 8;
    localparam int LEN_W     = 4;
    localparam int PAYLOAD_W = 64;
    localparam int OFFSET_W  = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_RESYNC_INDEX  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LENGTH = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PACKET  = 2'd0,
        CMD_UNLOCK  = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_READ    = 2'd3
    } t_cmd;

endpackage

// ===== src/chunked_telemetry_receiver_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_telemetry_receiver_core
// Receiving end of a stop-and-wait chunked link with a banked byte store.
// ----------------------------------------------------------------------------
// One item is accepted per clock cycle while o_in_stall is low. An accepted
// item passes two register stages: its result is registered in stage A and
// presented on the output from stage B, the output register. The session state
// (expected index, offset, confirm, finished) is updated in the accept cycle,
// and a packet writes its up to
// eight payload bytes in that same cycle into eight byte-wide banks, one
// write port per bank, so consecutive bytes always land in different banks.
// A read command reads all banks at one row into registers and selects the
// byte in the following stage, where the result waits in an output register;
// one further item is taken while a result is stalled. The byte store is not
// cleared by reset: read only bytes that were written. Configuration writes
// are always ready and must be issued only while the block is idle.
// ----------------------------------------------------------------------------
module chunked_telemetry_receiver_core
    import ctr_pkg::*;
#(
    parameter int STORE_DEPTH = 256,
    parameter int MAX_CHUNK   = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // Configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    // Input item channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [INDEX_W-1:0]    i_package_index,
    input  logic [LEN_W-1:0]      i_payload_len,
    input  logic [PAYLOAD_W-1:0]  i_payload,
    input  logic [BYTE_W-1:0]     i_read_addr,

    // Result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_confirm,
    output logic                  o_finished,
    output logic                  o_accepted,
    output logic [OFFSET_W-1:0]   o_fill_offset,
    output logic [BYTE_W-1:0]     o_read_data
);

    localparam int ROWS  = (STORE_DEPTH + NUM_BANKS - 1) / NUM_BANKS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ADDR_W = OFFSET_W + 1;

    // ------------------------------------------------------------------
    // Configuration and session state
    // ------------------------------------------------------------------
    logic [INDEX_W-1:0]  r_resync_index;
    logic [OFFSET_W-1:0] r_buf_len;
    logic [INDEX_W-1:0]  r_expected;
    logic [OFFSET_W-1:0] r_offset;
    logic                r_confirm;
    logic                r_done;

    logic [INDEX_W-1:0]  n_expected;
    logic [OFFSET_W-1:0] n_offset;
    logic                n_confirm;
    logic                n_done;
    logic                n_accepted;

    logic                in_accept;
    logic                cfg_write;
    logic                b_load;

    // Packet decode
    logic                pkt_take;
    logic [OFFSET_W-1:0] room;
    logic [LEN_W-1:0]    len_c;
    logic [LEN_W-1:0]    n_cnt;

    // Per-bank write and read controls
    logic [BANK_W-1:0]   lane_k   [NUM_BANKS];
    logic [ADDR_W-1:0]   lane_addr[NUM_BANKS];
    logic                bank_we  [NUM_BANKS];
    logic [ROW_W-1:0]    wr_row   [NUM_BANKS];
    logic [BYTE_W-1:0]   wr_data  [NUM_BANKS];
    logic [ROW_W-1:0]    rd_row;
    logic                rd_en;

    // Stage A: accepted item, results of the session update
    logic                r_a_valid;
    logic                r_a_confirm;
    logic                r_a_done;
    logic                r_a_accepted;
    logic [OFFSET_W-1:0] r_a_offset;
    logic                r_a_rd_en;
    logic [BANK_W-1:0]   r_a_rd_bank;
    logic [BYTE_W-1:0]   r_a_bank_data[NUM_BANKS];

    // Stage B: output register
    logic                r_b_valid;
    logic                r_b_confirm;
    logic                r_b_done;
    logic                r_b_accepted;
    logic [OFFSET_W-1:0] r_b_offset;
    logic [BYTE_W-1:0]   r_b_read_data;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid & o_cfg_ready;
    assign b_load      = r_a_valid & (~r_b_valid | ~i_out_stall);
    assign o_in_stall  = r_a_valid & ~b_load;
    assign in_accept   = i_in_valid & ~o_in_stall;

    // ------------------------------------------------------------------
    // Session update for the incoming item
    // ------------------------------------------------------------------
    always_comb begin
        n_expected = r_expected;
        n_offset   = r_offset;
        n_confirm  = r_confirm;
        n_done     = r_done;
        n_accepted = 1'b0;
        pkt_take   = 1'b0;

        // Room left in the buffer, clamped at zero
        room  = (r_offset > r_buf_len) ? '0 : r_buf_len - r_offset;
        len_c = (i_payload_len > LEN_W'(MAX_CHUNK)) ? LEN_W'(MAX_CHUNK) : i_payload_len;
        n_cnt = ({{(OFFSET_W-LEN_W){1'b0}}, len_c} < room) ? len_c : room[LEN_W-1:0];

        case (t_cmd'(i_cmd))
            CMD_PACKET: begin
                if (i_package_index == r_resync_index) begin
                    // Resync: restart the message and acknowledge
                    n_confirm  = ~r_confirm;
                    n_expected = INDEX_W'(1);
                    n_offset   = '0;
                    n_done     = 1'b0;
                end else if (!r_done) begin
                    if (i_package_index == '0 && r_expected > INDEX_W'(1)) begin
                        pkt_take = 1'b1;
                        n_done   = 1'b1;
                    end else if (i_package_index == r_expected) begin
                        pkt_take   = 1'b1;
                        n_expected = r_expected + INDEX_W'(1);
                    end
                    if (pkt_take) begin
                        n_offset   = r_offset + OFFSET_W'(n_cnt);
                        n_confirm  = ~r_confirm;
                        n_accepted = 1'b1;
                    end
                end
            end
            CMD_UNLOCK: begin
                if (r_done) begin
                    n_expected = INDEX_W'(1);
                    n_offset   = '0;
                    n_done     = 1'b0;
                end
            end
            CMD_RESTART: begin
                n_expected = INDEX_W'(1);
                n_offset   = '0;
                n_done     = 1'b0;
            end
            default: begin
                // read command leaves the session alone
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Map payload bytes onto banks: bank b takes byte (b - offset) mod 8
    // ------------------------------------------------------------------
    always_comb begin
        for (int b = 0; b < NUM_BANKS; b++) begin
            lane_k[b]    = BANK_W'(b) - r_offset[BANK_W-1:0];
            lane_addr[b] = {1'b0, r_offset} + ADDR_W'(lane_k[b]);
            bank_we[b]   = in_accept & pkt_take
                         & ({1'b0, lane_k[b]} < n_cnt)
                         & (lane_addr[b] < ADDR_W'(STORE_DEPTH));
            wr_row[b]    = lane_addr[b][ROW_W+BANK_W-1:BANK_W];
            wr_data[b]   = i_payload[lane_k[b]*BYTE_W +: BYTE_W];
        end
    end

    assign rd_row = i_read_addr[ROW_W+BANK_W-1:BANK_W];
    assign rd_en  = (t_cmd'(i_cmd) == CMD_READ)
                  & ({1'b0, i_read_addr} < ADDR_W'(STORE_DEPTH));

    // ------------------------------------------------------------------
    // Byte store: one bank per byte lane, one write and one read port each
    // ------------------------------------------------------------------
    for (genvar gb = 0; gb < NUM_BANKS; gb++) begin : g_bank
        logic [BYTE_W-1:0] r_mem [ROWS];

        always_ff @(posedge i_clk) begin
            if (bank_we[gb]) begin
                r_mem[wr_row[gb]] <= wr_data[gb];
            end
        end

        always_ff @(posedge i_clk) begin
            if (in_accept) begin
                r_a_bank_data[gb] <= r_mem[rd_row];
            end
        end
    end

    // ------------------------------------------------------------------
    // Session registers: configuration writes, then accepted items
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resync_index <= '0;
            r_buf_len      <= '0;
            r_expected     <= INDEX_W'(1);
            r_offset       <= '0;
            r_confirm      <= 1'b0;
            r_done         <= 1'b0;
        end else if (cfg_write) begin
            case (i_cfg_index)
                CFG_RESYNC_INDEX: begin
                    r_resync_index <= i_cfg_data;
                    r_expected     <= INDEX_W'(1);
                    r_offset       <= '0;
                    r_confirm      <= 1'b0;
                end
                CFG_BUFFER_LENGTH: begin
                    r_buf_len <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end else if (in_accept) begin
            r_expected <= n_expected;
            r_offset   <= n_offset;
            r_confirm  <= n_confirm;
            r_done     <= n_done;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: hold the accepted item's results
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_accept) begin
            r_a_valid <= 1'b1;
        end else if (b_load) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_confirm  <= n_confirm;
            r_a_done     <= n_done;
            r_a_accepted <= n_accepted;
            r_a_offset   <= n_offset;
            r_a_rd_en    <= rd_en;
            r_a_rd_bank  <= i_read_addr[BANK_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage B: output register, select the read byte
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_load) begin
            r_b_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_load) begin
            r_b_confirm   <= r_a_confirm;
            r_b_done      <= r_a_done;
            r_b_accepted  <= r_a_accepted;
            r_b_offset    <= r_a_offset;
            r_b_read_data <= r_a_rd_en ? r_a_bank_data[r_a_rd_bank] : '0;
        end
    end

    assign o_out_valid   = r_b_valid;
    assign o_confirm     = r_b_confirm;
    assign o_finished    = r_b_done;
    assign o_accepted    = r_b_accepted;
    assign o_fill_offset = r_b_offset;
    assign o_read_data   = r_b_read_data;

endmodule
